### sv/scp_pkg.sv
`timescale 1ns / 1ps
package scp_pkg;
  localparam int NUM_PROGRAMS = 8;
  localparam int MAX_STEPS = 64;
  localparam int MAX_ITEMS = 32;
  localparam int NUM_CHANNELS = 512;
  localparam int MIN_STEP_MS = 20;
  localparam int PW = 3;
  localparam int SW = 6;
  localparam int IW = 5;
  localparam int STW = 7;
  localparam int NW = 6;
  localparam int AW = 4;
  localparam int EW = 17;

  typedef enum logic [2:0] {
    K_FRAME = 3'd0, K_TICK = 3'd1, K_CLEAR = 3'd2, K_APPEND = 3'd3,
    K_PLAY = 3'd4, K_STOP = 3'd5, K_STOPALL = 3'd6, K_QUERY = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SLOT, S_RD, S_SCAN, S_TICK, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic prog_first;
    logic prog_next;
    logic item_next;
    logic slot_rd;
    logic scan_item;
    logic tick_prog;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_frame;
    logic is_tick;
    logic frame_skip;
    logic prog_live;
    logic prog_last;
    logic item_last;
  } sts_t;
endpackage

### sv/scp_datapath.sv
`timescale 1ns / 1ps
module scp_datapath import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic [2:0]  kind,
  input  logic [2:0]  program_req,
  input  logic [15:0] channel,
  input  logic [7:0]  level,
  input  logic        fx_owned,
  input  logic [15:0] step_time_ms,
  input  logic        last_item,
  input  logic        loop_mode,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        done,
  output logic [7:0]  merged_level,
  output logic [6:0]  step_total,
  output logic        program_active,
  output logic [3:0]  active_total
);
  logic [23:0] item_mem [NUM_PROGRAMS*MAX_STEPS*MAX_ITEMS];
  logic [15:0] dur_mem [NUM_PROGRAMS*MAX_STEPS];
  logic [NW-1:0] cnt_mem [NUM_PROGRAMS*MAX_STEPS];

  logic [9:0] tick_period;
  logic [STW-1:0] steps [NUM_PROGRAMS];
  logic [NW-1:0] pend [NUM_PROGRAMS];
  logic [NUM_PROGRAMS-1:0] playing, rpt;
  logic [SW-1:0] cur [NUM_PROGRAMS];
  logic [EW-1:0] elapsed [NUM_PROGRAMS];

  kind_t k_r;
  logic [PW-1:0] p_r;
  logic [15:0] ch_r, t_r;
  logic [7:0] lvl_r, best;
  logic fx_r, last_r, loop_r;

  logic [PW-1:0] sp;
  logic [IW-1:0] ki;
  logic [IW-1:0] ki_rd;
  logic [NW-1:0] n_r;
  logic [15:0] dur_r;
  logic [23:0] item_r;

  logic [SW-1:0] live;
  logic [SW+PW-1:0] slot;
  logic [SW+PW-1:0] aslot;
  logic [EW-1:0] el_sum;
  logic [NW-1:0] nclamp;
  logic [3:0] act;

  always_comb begin
    live = (7'(cur[sp]) < steps[sp]) ? cur[sp] : '0;
    slot = {sp, live};
    aslot = {p_r, steps[p_r][SW-1:0]};
    ki_rd = cmd.slot_rd ? '0 : ki + IW'(1);
    el_sum = elapsed[sp] + EW'(tick_period);
    nclamp = (n_r > NW'(MAX_ITEMS)) ? NW'(MAX_ITEMS) : n_r;
    sts.is_frame = (k_r == K_FRAME);
    sts.is_tick = (k_r == K_TICK);
    sts.frame_skip = fx_r || ch_r < 16'd1 || ch_r > 16'(NUM_CHANNELS);
    sts.prog_live = playing[sp] && steps[sp] != '0;
    sts.prog_last = (sp == PW'(NUM_PROGRAMS-1));
    sts.item_last = (nclamp == '0) || (NW'(ki) + NW'(1) >= nclamp);
    act = '0;
    for (int i = 0; i < NUM_PROGRAMS; i++) act = act + 4'(playing[i]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r <= kind_t'(kind); p_r <= program_req; ch_r <= channel; lvl_r <= level;
      fx_r <= fx_owned; t_r <= step_time_ms; last_r <= last_item; loop_r <= loop_mode;
      best <= level;
    end
    if (cmd.prog_first) sp <= '0;
    else if (cmd.prog_next) sp <= sp + PW'(1);
    if (cmd.slot_rd) begin
      n_r <= cnt_mem[slot];
      dur_r <= dur_mem[slot];
      ki <= '0;
    end else if (cmd.item_next) ki <= ki + IW'(1);
    item_r <= item_mem[{slot, ki_rd}];
    if (cmd.scan_item && n_r != '0 && item_r[23:8] == ch_r && item_r[7:0] > best)
      best <= item_r[7:0];
    if (cmd.exec && k_r == K_APPEND && steps[p_r] < STW'(MAX_STEPS)
        && pend[p_r] < NW'(MAX_ITEMS))
      item_mem[{aslot, pend[p_r][IW-1:0]}] <= {ch_r, lvl_r};
    if (cmd.exec && k_r == K_APPEND && steps[p_r] < STW'(MAX_STEPS) && last_r) begin
      cnt_mem[aslot] <= (pend[p_r] < NW'(MAX_ITEMS)) ? pend[p_r] + NW'(1) : pend[p_r];
      dur_mem[aslot] <= (t_r < 16'(MIN_STEP_MS)) ? 16'(MIN_STEP_MS) : t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= 10'd10;
      playing <= '0; rpt <= '0; done <= 1'b0;
      for (int i = 0; i < NUM_PROGRAMS; i++) begin
        steps[i] <= '0; pend[i] <= '0; cur[i] <= '0; elapsed[i] <= '0;
      end
    end else begin
      done <= cmd.emit;
      if (cfg_we) tick_period <= cfg_data;
      if (cmd.exec) begin
        unique case (k_r)
          K_CLEAR: begin
            playing[p_r] <= 1'b0; steps[p_r] <= '0; pend[p_r] <= '0;
          end
          K_APPEND: if (steps[p_r] < STW'(MAX_STEPS)) begin
            if (last_r) begin
              steps[p_r] <= steps[p_r] + STW'(1); pend[p_r] <= '0;
            end else if (pend[p_r] < NW'(MAX_ITEMS)) pend[p_r] <= pend[p_r] + NW'(1);
          end
          K_PLAY: if (steps[p_r] != '0) begin
            cur[p_r] <= '0; elapsed[p_r] <= '0; rpt[p_r] <= loop_r; playing[p_r] <= 1'b1;
          end
          K_STOP: playing[p_r] <= 1'b0;
          K_STOPALL: playing <= '0;
          default: ;
        endcase
      end
      if (cmd.tick_prog && playing[sp] && steps[sp] != '0) begin
        if (el_sum >= EW'(dur_r)) begin
          elapsed[sp] <= '0;
          if (7'(cur[sp]) + 7'd1 >= steps[sp]) begin
            cur[sp] <= '0;
            if (!rpt[sp]) playing[sp] <= 1'b0;
          end else cur[sp] <= cur[sp] + SW'(1);
        end else elapsed[sp] <= el_sum;
      end
    end
  end

  assign merged_level = (k_r == K_FRAME) ? best : '0;
  assign step_total = steps[p_r];
  assign program_active = playing[p_r];
  assign active_total = act;
endmodule

### sv/scp_ctrl.sv
`timescale 1ns / 1ps
module scp_ctrl import scp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SLOT;
      S_SLOT: begin
        if (sts.is_frame && !sts.frame_skip) state_next = S_RD;
        else if (sts.is_tick) state_next = S_RD;
        else state_next = S_DONE;
      end
      S_RD: begin
        if (!sts.prog_live) state_next = sts.prog_last ? S_DONE : S_RD;
        else state_next = sts.is_tick ? S_TICK : S_SCAN;
      end
      S_SCAN: if (sts.item_last) state_next = sts.prog_last ? S_DONE : S_RD;
      S_TICK: state_next = sts.prog_last ? S_DONE : S_RD;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: cmd.load = start;
      S_SLOT: begin
        cmd.exec = !sts.is_frame && !sts.is_tick;
        cmd.prog_first = 1'b1;
      end
      S_RD: begin
        cmd.slot_rd = sts.prog_live;
        cmd.prog_next = !sts.prog_live && !sts.prog_last;
      end
      S_SCAN: begin
        cmd.scan_item = 1'b1;
        cmd.item_next = !sts.item_last;
        cmd.prog_next = sts.item_last && !sts.prog_last;
      end
      S_TICK: begin
        cmd.tick_prog = 1'b1;
        cmd.prog_next = !sts.prog_last;
      end
      S_DONE: cmd.emit = 1'b1;
      default: ;
    endcase
  end
endmodule

### sv/sparse_cue_playback_htp_merge_top.sv
`timescale 1ns / 1ps
// Command-driven player for up to eight sparse lighting programs with HTP merge.
// Pulse start while busy is low; one result follows, marked by done for one cycle,
// and the receiver cannot stall it. A tick visits every program in turn; a frame
// item, unless fx_owned is set or the channel is out of range, walks each playing
// program's current step one stored pair per cycle from the item memory.
module sparse_cue_playback_htp_merge_top import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic [2:0]  kind,
  input  logic [2:0]  program_req,
  input  logic [15:0] channel,
  input  logic [7:0]  level,
  input  logic        fx_owned,
  input  logic [15:0] step_time_ms,
  input  logic        last_item,
  input  logic        loop_mode,
  output logic [7:0]  merged_level,
  output logic [6:0]  step_total,
  output logic        program_active,
  output logic [3:0]  active_total
);
  cmd_t cmd;
  sts_t sts;

  scp_ctrl u_ctrl (.clk, .rst, .start, .sts, .cmd, .busy);

  scp_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .kind, .program_req, .channel, .level,
    .fx_owned, .step_time_ms, .last_item, .loop_mode, .cmd, .sts, .done,
    .merged_level, .step_total, .program_active, .active_total
  );
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import scp_pkg::*;

  typedef struct packed {
    logic [7:0] merged;
    logic [6:0] steps;
    logic       active;
    logic [3:0] playing;
  } cue_result_t;

  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  logic        cfg_we;
  logic [9:0]  cfg_data;
  logic [2:0]  kind;
  logic [2:0]  program_req;
  logic [15:0] channel;
  logic [7:0]  level;
  logic        fx_owned;
  logic [15:0] step_time_ms;
  logic        last_item;
  logic        loop_mode;
  logic [7:0]  merged_level;
  logic [6:0]  step_total;
  logic        program_active;
  logic [3:0]  active_total;

  sparse_cue_playback_htp_merge_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .kind(kind), .program_req(program_req), .channel(channel), .level(level),
    .fx_owned(fx_owned), .step_time_ms(step_time_ms), .last_item(last_item),
    .loop_mode(loop_mode), .merged_level(merged_level), .step_total(step_total),
    .program_active(program_active), .active_total(active_total)
  );

  // player mirror
  logic [23:0] pair_mem [0:NUM_PROGRAMS*MAX_STEPS*MAX_ITEMS-1];
  int          dur_mem [0:NUM_PROGRAMS*MAX_STEPS-1];
  int          pair_cnt [0:NUM_PROGRAMS*MAX_STEPS-1];
  int          steps_m [NUM_PROGRAMS];
  int          pend_m [NUM_PROGRAMS];
  bit          play_m [NUM_PROGRAMS];
  bit          rep_m [NUM_PROGRAMS];
  int          cur_m [NUM_PROGRAMS];
  int          elapsed_m [NUM_PROGRAMS];
  int          period_m;

  cue_result_t expected_q[$];
  bit          failed;
  bit          no_gaps;
  int          stall_cnt;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int live_step(int p);
    return (cur_m[p] < steps_m[p] && cur_m[p] < MAX_STEPS) ? cur_m[p] : 0;
  endfunction

  function automatic cue_result_t predict_cue(kind_t k, int p, int ch, int lv, bit fx,
                                              int t, bit last, bit rep);
    cue_result_t r;
    int best;
    int slot;
    int n;
    int e_ch;
    int cnt;
    best = 0;
    case (k)
      K_FRAME: begin
        best = lv;
        if (!fx && ch >= 1 && ch <= NUM_CHANNELS) begin
          for (int q = 0; q < NUM_PROGRAMS; q++) begin
            if (play_m[q] && steps_m[q] != 0) begin
              slot = q * MAX_STEPS + live_step(q);
              n = pair_cnt[slot] > MAX_ITEMS ? MAX_ITEMS : pair_cnt[slot];
              for (int j = 0; j < n; j++) begin
                e_ch = pair_mem[slot*MAX_ITEMS + j][23:8];
                if (e_ch >= 1 && e_ch <= NUM_CHANNELS && e_ch == ch &&
                    pair_mem[slot*MAX_ITEMS + j][7:0] > best)
                  best = pair_mem[slot*MAX_ITEMS + j][7:0];
              end
            end
          end
        end
      end
      K_TICK: begin
        for (int q = 0; q < NUM_PROGRAMS; q++) begin
          if (play_m[q] && steps_m[q] != 0) begin
            slot = q * MAX_STEPS + live_step(q);
            elapsed_m[q] = (elapsed_m[q] + period_m) & 'h1FFFF;
            if (elapsed_m[q] >= dur_mem[slot]) begin
              elapsed_m[q] = 0;
              cur_m[q]++;
              if (cur_m[q] >= steps_m[q]) begin
                cur_m[q] = 0;
                if (!rep_m[q]) play_m[q] = 0;
              end
            end
          end
        end
      end
      K_CLEAR: begin
        play_m[p] = 0;
        steps_m[p] = 0;
        pend_m[p] = 0;
      end
      K_APPEND: begin
        if (steps_m[p] < MAX_STEPS) begin
          slot = p * MAX_STEPS + steps_m[p];
          if (pend_m[p] < MAX_ITEMS) begin
            pair_mem[slot*MAX_ITEMS + pend_m[p]] = {ch[15:0], lv[7:0]};
            pend_m[p]++;
          end
          if (last) begin
            pair_cnt[slot] = pend_m[p];
            dur_mem[slot] = t < MIN_STEP_MS ? MIN_STEP_MS : t;
            steps_m[p]++;
            pend_m[p] = 0;
          end
        end
      end
      K_PLAY: begin
        if (steps_m[p] != 0) begin
          cur_m[p] = 0;
          elapsed_m[p] = 0;
          rep_m[p] = rep;
          play_m[p] = 1;
        end
      end
      K_STOP: play_m[p] = 0;
      K_STOPALL: for (int q = 0; q < NUM_PROGRAMS; q++) play_m[q] = 0;
      default: ;
    endcase
    cnt = 0;
    for (int q = 0; q < NUM_PROGRAMS; q++) if (play_m[q]) cnt++;
    r.merged = best[7:0];
    r.steps = steps_m[p][6:0];
    r.active = play_m[p];
    r.playing = cnt[3:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(kind_t k, logic [2:0] p = 0, logic [15:0] ch = 0,
                           logic [7:0] lv = 0, logic fx = 0, logic [15:0] t = 0,
                           logic last = 0, logic rep = 0);
    int gap;
    kind <= k;
    program_req <= p;
    channel <= ch;
    level <= lv;
    fx_owned <= fx;
    step_time_ms <= t;
    last_item <= last;
    loop_mode <= rep;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_cue(k, p, ch, lv, fx, t, last, rep));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_period(int v);
    drain();
    cfg_data <= v[9:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_m = v;
    @(posedge clk);
  endtask

  task automatic append_step(int p, int n, int t, int ch_hi);
    for (int j = 0; j < n; j++)
      send_item(K_APPEND, p, $urandom_range(1, ch_hi), $urandom_range(0, 255), 0,
                t, j == n - 1);
  endtask

  task automatic test_directed();
    send_item(K_QUERY, 0);
    send_item(K_FRAME, 0, 1, 8'h00);
    send_item(K_APPEND, 7, 16'hFFFF, 8'hFF, 1, 16'hFFFF, 0);
    send_item(K_APPEND, 7, 512, 8'hFF, 0, 16'h0000, 1);
    send_item(K_APPEND, 7, 1, 8'h80, 0, 16'hFFFF, 1);
    send_item(K_PLAY, 7, 0, 0, 0, 0, 0, 1);
    send_item(K_PLAY, 3, 0, 0, 0, 0, 0, 1);
    send_item(K_FRAME, 5, 512, 8'h10);
    send_item(K_FRAME, 5, 512, 8'h10, 1);
    send_item(K_FRAME, 5, 513, 8'h10);
    send_item(K_FRAME, 5, 0, 8'hFF);
    send_item(K_FRAME, 5, 16'hFFFF, 8'h01);
    send_item(K_TICK);
    send_item(K_TICK);
    send_item(K_FRAME, 0, 1, 8'h7F);
    send_item(K_STOP, 3);
    send_item(K_STOP, 7);
    send_item(K_STOP, 7);
    send_item(K_PLAY, 7, 0, 0, 0, 0, 0, 0);
    send_item(K_STOPALL);
    send_item(K_CLEAR, 7);
    send_item(K_QUERY, 7);
  endtask

  task automatic test_item_overflow();
    append_step(2, MAX_ITEMS + 3, 25, 8);
    send_item(K_APPEND, 2, 0, 8'h55, 0, 30, 0);
    send_item(K_CLEAR, 2);
    append_step(2, 3, 20, 4);
    send_item(K_PLAY, 2, 0, 0, 0, 0, 0, 1);
    for (int c = 1; c <= 8; c++) send_item(K_FRAME, 1, c, 0);
    send_item(K_CLEAR, 2);
  endtask

  task automatic test_full_program();
    no_gaps = 1;
    for (int s = 0; s < MAX_STEPS + 2; s++) append_step(4, 1, 20, 6);
    no_gaps = 0;
    send_item(K_PLAY, 4, 0, 0, 0, 0, 0, 0);
    repeat (3) send_item(K_TICK);
    send_item(K_FRAME, 4, $urandom_range(1, 6), 0);
    send_item(K_CLEAR, 4);
  endtask

  task automatic test_random(int count);
    int sent;
    int r;
    int p;
    int t;
    sent = 0;
    while (sent < count) begin
      no_gaps = ($urandom_range(0, 15) == 0);
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 7);
      if (r < 25) begin
        r = $urandom_range(1, 5);
        t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 80);
        append_step(p, r, t, ($urandom_range(0, 7) == 0) ? 65535 : 16);
        sent += r;
      end else if (r < 35) begin
        send_item(K_PLAY, p, 0, 0, 0, 0, 0, $urandom_range(0, 1));
        sent++;
      end else if (r < 60) begin
        send_item(K_FRAME, p, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
                  $urandom_range(1, 16), $urandom_range(0, 255), $urandom_range(0, 4) == 0);
        sent++;
      end else if (r < 80) begin
        send_item(K_TICK);
        sent++;
      end else if (r < 84) begin
        send_item(K_STOP, p);
        sent++;
      end else if (r < 87) begin
        send_item(K_CLEAR, p);
        sent++;
      end else if (r < 88) begin
        send_item(K_STOPALL);
        sent++;
      end else if (r < 92) begin
        send_item(K_QUERY, p);
        sent++;
      end else begin
        send_item(kind_t'($urandom_range(0, 7)), p, $urandom_range(0, 65535),
                  $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 65535),
                  $urandom_range(0, 1), $urandom_range(0, 1));
        sent++;
      end
    end
    no_gaps = 0;
  endtask

  always @(posedge clk) begin
    cue_result_t exp_r;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %0d %0d %0d %0d", $time,
                 merged_level, step_total, program_active, active_total);
        failed = 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (merged_level !== exp_r.merged) begin
          $display("%0t: merged_level expected %0d actual %0d", $time, exp_r.merged,
                   merged_level);
          failed = 1;
        end
        if (step_total !== exp_r.steps) begin
          $display("%0t: step_total expected %0d actual %0d", $time, exp_r.steps, step_total);
          failed = 1;
        end
        if (program_active !== exp_r.active) begin
          $display("%0t: program_active expected %0d actual %0d", $time, exp_r.active,
                   program_active);
          failed = 1;
        end
        if (active_total !== exp_r.playing) begin
          $display("%0t: active_total expected %0d actual %0d", $time, exp_r.playing,
                   active_total);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("** sparse_cue_playback_htp_merge_top: FAILED **");
      $finish;
    end
  end

  initial begin
    no_gaps = 0;
    period_m = 10;
    for (int q = 0; q < NUM_PROGRAMS; q++) begin
      steps_m[q] = 0;
      pend_m[q] = 0;
      play_m[q] = 0;
      rep_m[q] = 0;
      cur_m[q] = 0;
      elapsed_m[q] = 0;
    end
    rst = 1;
    start = 0;
    cfg_we = 0;
    cfg_data = 0;
    kind = K_QUERY;
    program_req = 0;
    channel = 0;
    level = 0;
    fx_owned = 0;
    step_time_ms = 0;
    last_item = 0;
    loop_mode = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed();
    write_period(1000);
    test_item_overflow();
    write_period(1);
    test_full_program();
    write_period(22);
    test_random(100);
    write_period($urandom_range(1, 1000));
    test_random(100);
    write_period(1);
    test_random(70);
    write_period(10);
    test_random(70);

    drain();
    repeat (300) @(posedge clk);
    if (!failed && expected_q.size() == 0)
      $display("** sparse_cue_playback_htp_merge_top: PASSED **");
    else
      $display("** sparse_cue_playback_htp_merge_top: FAILED **");
    $finish;
  end
endmodule
